// ----- src/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Shared field widths, codes, register map and record types.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W      = 32;
  localparam int TIME_W     = 32;
  localparam int RETRY_W    = 8;
  localparam int FUNC_W     = 2;
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 3;
  localparam int CNT_OUT_W  = 4;
  localparam int LIMIT_W    = 4;
  localparam int TMO_W      = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int MAX_RESULTS = 8;

  // Input item function codes
  localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TRANSMIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW_LIMIT = 1'b0;
  localparam logic REG_TIMEOUT      = 1'b1;

  localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST = 4'd8;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST      = 16'd2;

  typedef struct packed {
    logic [LIMIT_W-1:0] window_limit;
    logic [TMO_W-1:0]   timeout_seconds;
  } cfg_t;

  // One ring slot: only ever read while occupied, so no reset value
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  stamp;
    logic [RETRY_W-1:0] retry;
    logic               sent;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot;
    logic [SEQ_W-1:0]     frame_seq;
    logic [RETRY_W-1:0]   retries;
    logic [CNT_OUT_W-1:0] acked_count;
    logic [CNT_OUT_W-1:0] outstanding;
    logic                 last;
  } result_t;

  function automatic logic [RETRY_W-1:0] retry_inc(input logic [RETRY_W-1:0] r);
    return (r == {RETRY_W{1'b1}}) ? r : r + RETRY_W'(1);
  endfunction

endpackage

// ----- src/gbn_if.sv -----
// ----------------------------------------------------------------------------
// Go-Back-N sender channels
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface gbn_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [gbn_pkg::FUNC_W-1:0]  func;
  logic [gbn_pkg::SEQ_W-1:0]   seq;
  logic [gbn_pkg::TIME_W-1:0]  now;

  modport source (output valid, func, seq, now, input ready);
  modport sink   (input valid, func, seq, now, output ready);
endinterface

interface gbn_res_if;
  logic                          valid;
  logic                          ready;
  logic [gbn_pkg::KIND_W-1:0]    kind;
  logic [gbn_pkg::SLOT_W-1:0]    slot;
  logic [gbn_pkg::SEQ_W-1:0]     frame_seq;
  logic [gbn_pkg::RETRY_W-1:0]   retries;
  logic [gbn_pkg::CNT_OUT_W-1:0] acked_count;
  logic [gbn_pkg::CNT_OUT_W-1:0] outstanding;
  logic                          last;

  modport source (output valid, kind, slot, frame_seq, retries, acked_count, outstanding,
                  last, input ready);
  modport sink   (input valid, kind, slot, frame_seq, retries, acked_count, outstanding,
                  last, output ready);
endinterface

// ----- src/gbn_cfg.sv -----
// ----------------------------------------------------------------------------
// Go-Back-N sender configuration registers
// APB-style register file holding the scan limit and the timeout.
// ----------------------------------------------------------------------------
module gbn_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gbn_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gbn_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gbn_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output gbn_pkg::cfg_t                    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_limit    <= gbn_pkg::WINDOW_LIMIT_RST;
      cfg.timeout_seconds <= gbn_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        gbn_pkg::REG_WINDOW_LIMIT: begin
          cfg.window_limit <= pwdata[gbn_pkg::LIMIT_W-1:0];
        end
        gbn_pkg::REG_TIMEOUT: begin
          cfg.timeout_seconds <= pwdata[gbn_pkg::TMO_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gbn_pkg::REG_WINDOW_LIMIT: begin
        prdata = gbn_pkg::APB_DATA_W'(cfg.window_limit);
      end
      gbn_pkg::REG_TIMEOUT: begin
        prdata = gbn_pkg::APB_DATA_W'(cfg.timeout_seconds);
      end
    endcase
  end

endmodule

// ----- src/go_back_n_sender_window.sv -----
// ----------------------------------------------------------------------------
// Go-Back-N sender window
// Ring of frame slots with enqueue/transmit, cumulative ack and go-back-n
// retransmission on timeout, walked one slot per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one transaction per command (func, seq, now). Enqueue stores a frame
//         in the tail slot and sends every ready frame in the scanned window;
//         ack retires head frames whose sequence is below seq; timeout check
//         resends every sent frame in the scanned window once any of them has aged past the timeout.
//   res : transmit records, one ack status, or an enqueue-full reject. The
//         final record of a command carries last = 1. Commands that send
//         nothing give no record.
//   APB : register 0 window_limit (addr 0), register 1 timeout_seconds (addr 4).
// Timing: cmd.ready is high only while the sequencer is idle. A slot memory
//   with one read and one write port feeds a single compare/update stage, one
//   slot per cycle while the output does not stall. Enqueue walks the scan
//   length n (at most 8), a timeout check walks it once and again to resend,
//   and an ack walks the occupied slots until one is not below seq; a reject
//   goes straight to the flush state and an unused code back to idle.
// Reset: the window empties (head and occupancy cleared); slot contents are
//   only read while occupied and need no clearing pass. Config registers
//   return to window_limit 8 and timeout 2.
// Stall: records leave through a holding stage and an output register; a
//   stalled receiver freezes the slot walk until the output frees up.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
  parameter int WINDOW_SLOTS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  gbn_cmd_if.sink                        cmd,
  gbn_res_if.source                      res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gbn_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gbn_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gbn_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int IW       = $clog2(WINDOW_SLOTS);
  localparam int CW       = $clog2(WINDOW_SLOTS + 1);
  localparam int SCAN_CAP = (WINDOW_SLOTS < gbn_pkg::MAX_RESULTS) ?
                            WINDOW_SLOTS : gbn_pkg::MAX_RESULTS;
  localparam logic [IW:0]   WS_WIDE = (IW + 1)'(WINDOW_SLOTS);
  localparam logic [CW-1:0] WS_CNT  = CW'(WINDOW_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEND  = 5'b00010,
    S_CHECK = 5'b00100,
    S_ACK   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] b,
                                             input logic [CW-1:0] o);
    logic [IW:0] s;
    s = (IW + 1)'(b) + (IW + 1)'(o);
    if (s >= WS_WIDE) s = s - WS_WIDE;
    return s[IW-1:0];
  endfunction

  function automatic logic [gbn_pkg::CNT_OUT_W-1:0] sat15(input logic [CW-1:0] v);
    return (32'(v) > 32'd15) ? 4'd15 : gbn_pkg::CNT_OUT_W'(v);
  endfunction

  gbn_pkg::cfg_t cfg;

  gbn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Control state
  state_t          state;
  logic [IW-1:0]   head;
  logic [CW-1:0]   count;
  logic [IW-1:0]   base;
  logic [CW-1:0]   off;
  logic [CW-1:0]   lim;
  logic            bump;
  logic            expired;
  logic            ack_go;
  logic [CW-1:0]   acked;
  logic            stg_valid;
  logic            hold_valid;
  logic            out_valid;

  // Payload
  logic [gbn_pkg::SEQ_W-1:0]  seq_q;
  logic [gbn_pkg::TIME_W-1:0] now_q;
  logic [CW-1:0]              stg_off;
  logic [IW-1:0]              stg_idx;
  gbn_pkg::entry_t            rd_entry;
  gbn_pkg::result_t           hold;
  gbn_pkg::result_t           out_res;
  gbn_pkg::result_t           out_next;

  gbn_pkg::entry_t            slot_mem [WINDOW_SLOTS];

  // Datapath
  logic                       accept;
  logic                       full;
  logic [IW-1:0]              tail;
  logic [CW-1:0]              scan_len;
  logic                       scanning;
  logic                       issue_ok;
  logic                       issue;
  logic                       phase_end;
  logic [IW-1:0]              rd_addr;
  logic                       stg_occ;
  logic                       tx_hit;
  logic                       out_free;
  logic                       stall;
  logic                       ack_less;
  logic                       ack_retire;
  logic                       ack_stop;
  logic                       aged;
  logic [gbn_pkg::RETRY_W-1:0] new_retry;
  logic                       mem_we;
  logic [IW-1:0]              mem_waddr;
  gbn_pkg::entry_t            mem_wdata;
  gbn_pkg::result_t           tx_res;
  gbn_pkg::result_t           ack_res;
  gbn_pkg::result_t           rej_res;
  logic                       flush_move;
  logic                       out_load;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == WS_CNT);
  assign tail      = ring_add(head, count);

  // Scan length: window_limit capped at the ring size and the result cap
  assign scan_len = (32'(cfg.window_limit) > 32'(SCAN_CAP)) ?
                    CW'(SCAN_CAP) : CW'(cfg.window_limit);

  assign scanning  = (state == S_SEND) || (state == S_CHECK) || (state == S_ACK);
  assign issue_ok  = (off < lim) && !((state == S_ACK) && !ack_go);
  assign rd_addr   = ring_add(base, off);
  assign stg_occ   = (stg_off < count);
  assign out_free  = !out_valid || res.ready;

  // Send: every occupied slot that is ready, or every occupied slot on resend
  assign tx_hit    = (state == S_SEND) && stg_valid && stg_occ && (!rd_entry.sent || bump);
  assign stall     = tx_hit && hold_valid && !out_free;
  assign issue     = scanning && issue_ok && !stall;
  assign phase_end = scanning && !issue_ok && !stg_valid;

  assign ack_less   = (rd_entry.seq < seq_q);
  assign ack_retire = (state == S_ACK) && stg_valid && ack_go && ack_less;
  assign ack_stop   = (state == S_ACK) && stg_valid && ack_go && !ack_less;

  assign aged      = ((now_q - rd_entry.stamp) > gbn_pkg::TIME_W'(cfg.timeout_seconds));
  assign new_retry = (bump && rd_entry.sent) ? gbn_pkg::retry_inc(rd_entry.retry) :
                     rd_entry.retry;

  // Single write port: enqueue in idle, write-back of a sent slot otherwise
  assign mem_we    = (accept && (cmd.func == gbn_pkg::FUNC_ENQUEUE) && !full) ||
                     (tx_hit && !stall);
  assign mem_waddr = (state == S_IDLE) ? tail : stg_idx;

  always_comb begin
    if (state == S_IDLE) begin
      mem_wdata.seq   = cmd.seq;
      mem_wdata.stamp = cmd.now;
      mem_wdata.retry = '0;
      mem_wdata.sent  = 1'b0;
    end else begin
      mem_wdata.seq   = rd_entry.seq;
      mem_wdata.stamp = now_q;
      mem_wdata.retry = new_retry;
      mem_wdata.sent  = 1'b1;
    end
  end

  always_comb begin
    tx_res.kind        = gbn_pkg::KIND_TRANSMIT;
    tx_res.slot        = gbn_pkg::SLOT_W'(stg_idx);
    tx_res.frame_seq   = rd_entry.seq;
    tx_res.retries     = new_retry;
    tx_res.acked_count = '0;
    tx_res.outstanding = sat15(count);
    tx_res.last        = 1'b0;

    ack_res             = '0;
    ack_res.kind        = gbn_pkg::KIND_ACK;
    ack_res.acked_count = sat15(acked);
    ack_res.outstanding = sat15(count);

    rej_res             = '0;
    rej_res.kind        = gbn_pkg::KIND_REJECT;
    rej_res.outstanding = sat15(count);
  end

  // Output register takes the held record when a newer one displaces it, or
  // at the end of the command as the final record
  assign flush_move = (state == S_FLUSH) && hold_valid && out_free;
  assign out_load   = (tx_hit && !stall && hold_valid) || flush_move;

  always_comb begin
    out_next      = hold;
    out_next.last = flush_move;
  end

  assign res.valid       = out_valid;
  assign res.kind        = out_res.kind;
  assign res.slot        = out_res.slot;
  assign res.frame_seq   = out_res.frame_seq;
  assign res.retries     = out_res.retries;
  assign res.acked_count = out_res.acked_count;
  assign res.outstanding = out_res.outstanding;
  assign res.last        = out_res.last;

  // Slot memory: registered read on issue, one write a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_entry <= slot_mem[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_q <= cmd.seq;
      now_q <= cmd.now;
    end
    if (issue) begin
      stg_off <= off;
      stg_idx <= rd_addr;
    end
    if (out_load) begin
      out_res <= out_next;
    end
    if (accept && (cmd.func == gbn_pkg::FUNC_ENQUEUE) && full) begin
      hold <= rej_res;
    end else if (tx_hit && !stall) begin
      hold <= tx_res;
    end else if ((state == S_ACK) && phase_end) begin
      hold <= ack_res;
    end
  end

  // Sequencer and window control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      base       <= '0;
      off        <= '0;
      lim        <= '0;
      bump       <= 1'b0;
      expired    <= 1'b0;
      ack_go     <= 1'b0;
      acked      <= '0;
      stg_valid  <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Slot walk: advance the offset on each read, hold everything on stall
      if (!stall) begin
        stg_valid <= issue;
      end
      if (issue) begin
        off <= off + CW'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      if (state == S_CHECK && stg_valid && stg_occ && rd_entry.sent && aged) begin
        expired <= 1'b1;
      end

      if (ack_retire) begin
        head  <= ring_add(head, CW'(1));
        count <= count - CW'(1);
        acked <= acked + CW'(1);
      end
      if (ack_stop) begin
        ack_go <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            base <= head;
            off  <= '0;
            unique case (cmd.func)
              gbn_pkg::FUNC_ENQUEUE: begin
                if (full) begin
                  hold_valid <= 1'b1;
                  state      <= S_FLUSH;
                end else begin
                  count <= count + CW'(1);
                  lim   <= scan_len;
                  bump  <= 1'b0;
                  state <= S_SEND;
                end
              end
              gbn_pkg::FUNC_ACK: begin
                lim    <= count;
                acked  <= '0;
                ack_go <= 1'b1;
                state  <= S_ACK;
              end
              gbn_pkg::FUNC_TIMEOUT: begin
                lim     <= scan_len;
                expired <= 1'b0;
                state   <= S_CHECK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SEND: begin
          if (tx_hit && !stall) begin
            hold_valid <= 1'b1;
          end
          if (phase_end) begin
            state <= S_FLUSH;
          end
        end
        S_CHECK: begin
          if (phase_end) begin
            if (expired) begin
              off   <= '0;
              bump  <= 1'b1;
              state <= S_SEND;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ACK: begin
          if (phase_end) begin
            hold_valid <= 1'b1;
            state      <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Occupancy never exceeds the ring
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= WINDOW_SLOTS)
    else $error("window occupancy above ring size");

  // A stalled slot walk must not write back or read ahead
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    stall |-> (!mem_we && !issue))
    else $error("slot walk moved during output stall");

  // Ack retires at most one frame per cycle
  a_ack_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACK) |=> (count == $past(count) || count == $past(count) - CW'(1)))
    else $error("ack retired more than one frame in a cycle");

  // The record in the output register holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(out_res)))
    else $error("pending record changed before it was taken");

endmodule

// ----- tb/gbn_window_checker.sv -----
// ----------------------------------------------------------------------------
// Go-Back-N sender window checker
// Watches the command, result and register ports, keeps its own copy of the
// slot ring, and compares every result transaction with the oldest frame due.
// ----------------------------------------------------------------------------
module gbn_window_checker (
  input  logic                           clk,
  input  logic                           rst,
  gbn_cmd_if                             cmd,
  gbn_res_if                             res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [gbn_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gbn_pkg::APB_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             pending
);

  localparam int RING = 8;

  typedef enum logic [1:0] {SLOT_EMPTY, SLOT_READY, SLOT_SENT} slot_state_t;

  slot_state_t                   state_q [RING];
  logic [gbn_pkg::SEQ_W-1:0]     seq_q   [RING];
  logic [gbn_pkg::TIME_W-1:0]    stamp_q [RING];
  logic [gbn_pkg::RETRY_W-1:0]   retry_q [RING];
  logic [gbn_pkg::SLOT_W-1:0]    head_q;
  logic [gbn_pkg::CNT_OUT_W-1:0] count_q;
  logic [gbn_pkg::LIMIT_W-1:0]   limit_q;
  logic [gbn_pkg::TMO_W-1:0]     tmo_q;

  gbn_pkg::result_t frames_due [$];

  function automatic int scan_len();
    int n;
    n = int'(limit_q);
    if (n > RING) n = RING;
    if (n > gbn_pkg::MAX_RESULTS) n = gbn_pkg::MAX_RESULTS;
    return n;
  endfunction

  function automatic int ring_slot(input int offset);
    return (int'(head_q) + offset) % RING;
  endfunction

  // Send every ready slot in the scanned part of the window.
  task automatic send_ready(input logic [gbn_pkg::TIME_W-1:0] now,
                            ref gbn_pkg::result_t batch [$]);
    gbn_pkg::result_t r;
    int               idx;
    for (int i = 0; i < scan_len(); i++) begin
      idx = ring_slot(i);
      if (state_q[idx] == SLOT_READY) begin
        state_q[idx] = SLOT_SENT;
        stamp_q[idx] = now;
        r = '0;
        r.kind = gbn_pkg::KIND_TRANSMIT;
        r.slot = gbn_pkg::SLOT_W'(idx);
        r.frame_seq = seq_q[idx];
        r.retries = retry_q[idx];
        batch.push_back(r);
      end
    end
  endtask

  task automatic advance_window(input logic [gbn_pkg::FUNC_W-1:0] func,
                                input logic [gbn_pkg::SEQ_W-1:0] seq,
                                input logic [gbn_pkg::TIME_W-1:0] now);
    gbn_pkg::result_t           batch [$];
    gbn_pkg::result_t           r;
    int                         idx;
    int                         acked;
    bit                         expired;
    logic [gbn_pkg::TIME_W-1:0] age;
    case (func)
      gbn_pkg::FUNC_ENQUEUE: begin
        if (count_q >= RING) begin
          r = '0;
          r.kind = gbn_pkg::KIND_REJECT;
          batch.push_back(r);
        end else begin
          idx = ring_slot(int'(count_q));
          seq_q[idx] = seq;
          state_q[idx] = SLOT_READY;
          retry_q[idx] = '0;
          count_q++;
          send_ready(now, batch);
        end
      end
      gbn_pkg::FUNC_ACK: begin
        acked = 0;
        while (count_q > 0 && seq_q[head_q] < seq) begin
          state_q[head_q] = SLOT_EMPTY;
          head_q++;
          count_q--;
          acked++;
        end
        r = '0;
        r.kind = gbn_pkg::KIND_ACK;
        r.acked_count = gbn_pkg::CNT_OUT_W'(acked);
        batch.push_back(r);
      end
      gbn_pkg::FUNC_TIMEOUT: begin
        expired = 1'b0;
        for (int i = 0; i < scan_len(); i++) begin
          idx = ring_slot(i);
          age = now - stamp_q[idx];
          if (state_q[idx] == SLOT_SENT && age > gbn_pkg::TIME_W'(tmo_q)) expired = 1'b1;
        end
        if (expired) begin
          for (int i = 0; i < scan_len(); i++) begin
            idx = ring_slot(i);
            if (state_q[idx] == SLOT_SENT) begin
              state_q[idx] = SLOT_READY;
              if (retry_q[idx] != '1) retry_q[idx]++;
            end
          end
          send_ready(now, batch);
        end
      end
      default: ;
    endcase
    for (int k = 0; k < batch.size(); k++) begin
      r = batch[k];
      r.outstanding = count_q;
      r.last = (k == batch.size() - 1);
      frames_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gbn_pkg::result_t want;
    if (rst) begin
      for (int i = 0; i < RING; i++) begin
        state_q[i] = SLOT_EMPTY;
        seq_q[i] = '0;
        stamp_q[i] = '0;
        retry_q[i] = '0;
      end
      head_q = '0;
      count_q = '0;
      limit_q = gbn_pkg::WINDOW_LIMIT_RST;
      tmo_q = gbn_pkg::TIMEOUT_RST;
      frames_due.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d frame_seq %0d", res.kind, res.slot,
                 res.frame_seq);
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("kind", want.kind, res.kind);
          check_field("slot", want.slot, res.slot);
          check_field("frame_seq", want.frame_seq, res.frame_seq);
          check_field("retries", want.retries, res.retries);
          check_field("acked_count", want.acked_count, res.acked_count);
          check_field("outstanding", want.outstanding, res.outstanding);
          check_field("last", want.last, res.last);
        end
      end
      if (cmd.valid && cmd.ready) advance_window(cmd.func, cmd.seq, cmd.now);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == gbn_pkg::REG_WINDOW_LIMIT) limit_q = pwdata[gbn_pkg::LIMIT_W-1:0];
        else tmo_q = pwdata[gbn_pkg::TMO_W-1:0];
      end
      pending <= frames_due.size();
    end
  end

endmodule

// ----- tb/go_back_n_sender_window_test.sv -----
// ----------------------------------------------------------------------------
// Go-Back-N sender window test
// Drives directed and random command transactions under a sequence of window
// and timeout settings, with random result stalls and command gaps; the checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_test;

  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 5;
  localparam int SAT_CHECKS    = 256;
  // Longest walk is a resending timeout check plus the output stages.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [gbn_pkg::APB_ADDR_W-1:0] ADDR_WINDOW_LIMIT = 3'd0;
  localparam logic [gbn_pkg::APB_ADDR_W-1:0] ADDR_TIMEOUT      = 3'd4;
  localparam logic [gbn_pkg::FUNC_W-1:0]     FUNC_UNUSED       = 2'd3;

  // Window and timeout per phase: extremes of both registers included.
  localparam logic [gbn_pkg::LIMIT_W-1:0] LIMIT_PLAN [NUM_PHASES] = '{
    4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd9, 4'd8
  };
  localparam logic [gbn_pkg::TMO_W-1:0] TMO_PLAN [NUM_PHASES] = '{
    16'd2, 16'd0, 16'd65535, 16'd5, 16'd3, 16'd1, 16'd7
  };

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [gbn_pkg::APB_ADDR_W-1:0] paddr;
  logic [gbn_pkg::APB_DATA_W-1:0] pwdata;
  logic [gbn_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  gbn_cmd_if cmd_ch ();
  gbn_res_if res_ch ();

  int fail_count;
  int pending;
  int cycle_count;
  int stall_left;
  logic quiet;

  logic [gbn_pkg::SEQ_W-1:0]  next_seq;
  logic [gbn_pkg::TIME_W-1:0] cur_time;
  logic [gbn_pkg::TMO_W-1:0]  tmo_now;

  go_back_n_sender_window dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gbn_window_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, never once the run goes quiet.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Present one command and hold it until the block takes it. Valid stays
  // high on return so a following command goes out back to back.
  task automatic issue_command(input logic [gbn_pkg::FUNC_W-1:0] f,
                               input logic [gbn_pkg::SEQ_W-1:0] s,
                               input logic [gbn_pkg::TIME_W-1:0] t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= f;
    cmd_ch.seq <= s;
    cmd_ch.now <= t;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // One APB write. Leave psel high so a second write can follow directly
  // with its setup cycle; the caller drops the bus afterwards.
  task automatic write_register(input logic [gbn_pkg::APB_ADDR_W-1:0] a,
                                input logic [gbn_pkg::APB_DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Drop valid, wait for every predicted result, then let a silent walk
  // (a command that sends nothing) run out before touching the registers.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [gbn_pkg::LIMIT_W-1:0] lim,
                           input logic [gbn_pkg::TMO_W-1:0] tmo);
    // Upper data bits carry noise; only the register's own width counts.
    write_register(ADDR_WINDOW_LIMIT, ($urandom & ~32'hF) | gbn_pkg::APB_DATA_W'(lim));
    write_register(ADDR_TIMEOUT, ($urandom & ~32'hFFFF) | gbn_pkg::APB_DATA_W'(tmo));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tmo_now = tmo;
  endtask

  task automatic bump_seq();
    // Skip the all-ones number: no ack can ever retire it.
    next_seq = next_seq + 1;
    if (next_seq == '1) next_seq = '0;
  endtask

  // Mostly a well-formed flow: in-order frames, cumulative acks just behind
  // the send point, and timeout checks, with time nudged past the timeout now
  // and then. The rest is noise: random numbers, time jumps, unused codes.
  task automatic random_command(output bit counted);
    int                         pick;
    int                         tsel;
    logic [gbn_pkg::FUNC_W-1:0] f;
    logic [gbn_pkg::SEQ_W-1:0]  s;
    logic [gbn_pkg::TIME_W-1:0] t;
    pick = $urandom_range(0, 99);
    tsel = $urandom_range(0, 99);
    if (tsel < 80) cur_time = cur_time + $urandom_range(0, 2);
    else if (tsel < 95) cur_time = cur_time + tmo_now + $urandom_range(1, 3);
    else cur_time = $urandom;
    t = cur_time;
    counted = 1'b1;
    if (pick < 45) begin
      f = gbn_pkg::FUNC_ENQUEUE;
      s = next_seq;
      bump_seq();
      if (pick < 4) s = $urandom;
    end else if (pick < 68) begin
      f = gbn_pkg::FUNC_ACK;
      s = next_seq - $urandom_range(0, 9);
    end else if (pick < 72) begin
      // Flush: retire everything, including frames stranded behind a wrap.
      f = gbn_pkg::FUNC_ACK;
      s = '1;
    end else if (pick < 93) begin
      f = gbn_pkg::FUNC_TIMEOUT;
      s = $urandom;
    end else if (pick < 96) begin
      f = FUNC_UNUSED;
      s = $urandom;
      counted = 1'b0;
    end else begin
      f = gbn_pkg::FUNC_W'($urandom_range(0, 3));
      s = $urandom;
      t = $urandom;
      counted = (f != FUNC_UNUSED);
    end
    issue_command(f, s, t);
  endtask

  initial begin
    int counted_items;
    bit counted;

    rst <= 1'b1;
    quiet <= 1'b0;
    cycle_count <= 0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.func <= gbn_pkg::FUNC_ENQUEUE;
    cmd_ch.seq <= '0;
    cmd_ch.now <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    next_seq = '0;
    cur_time = '0;
    tmo_now = gbn_pkg::TIMEOUT_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings (window 8, timeout 2).
    issue_command(gbn_pkg::FUNC_ACK, 32'd0, 32'd0);          // ack on an empty window
    issue_command(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // ignored code
    issue_command(gbn_pkg::FUNC_ENQUEUE, 32'd0, 32'd10);
    issue_command(gbn_pkg::FUNC_ENQUEUE, 32'hFFFF_FFFE, 32'd11);
    issue_command(gbn_pkg::FUNC_TIMEOUT, 32'd0, 32'd12);     // age equals timeout: silent
    issue_command(gbn_pkg::FUNC_TIMEOUT, 32'd0, 32'd13);     // age exceeds it: resend both
    for (int i = 1; i <= 6; i++) begin
      issue_command(gbn_pkg::FUNC_ENQUEUE, gbn_pkg::SEQ_W'(i), 32'd14);
    end
    issue_command(gbn_pkg::FUNC_ENQUEUE, 32'd7, 32'd15);     // ring full: reject
    issue_command(gbn_pkg::FUNC_ACK, 32'd0, 32'd15);         // nothing below zero
    issue_command(gbn_pkg::FUNC_ACK, 32'd1, 32'd15);         // head only, blocked by a big one
    issue_command(gbn_pkg::FUNC_TIMEOUT, 32'hFFFF_FFFF, 32'hFFFF_FFF0); // time ran backward
    issue_command(gbn_pkg::FUNC_TIMEOUT, 32'd0, 32'd5);      // age across the wrap
    issue_command(gbn_pkg::FUNC_ACK, 32'hFFFF_FFFF, 32'd5);  // retire the whole window
    issue_command(gbn_pkg::FUNC_ENQUEUE, 32'h7FFF_FFFF, 32'd6);
    issue_command(gbn_pkg::FUNC_ACK, 32'h8000_0000, 32'd6);
    cur_time = 32'd6;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        // Drive one frame's retry count into saturation with a single slot
        // scanned and a zero timeout, then clear it out.
        issue_command(gbn_pkg::FUNC_ACK, '1, cur_time);
        wait_drained();
        configure(4'd1, 16'd0);
        issue_command(gbn_pkg::FUNC_ENQUEUE, 32'd100, cur_time);
        repeat (SAT_CHECKS) begin
          cur_time = cur_time + 1;
          issue_command(gbn_pkg::FUNC_TIMEOUT, $urandom, cur_time);
        end
        issue_command(gbn_pkg::FUNC_ACK, '1, cur_time);
        // Last part runs with both sides streaming.
        quiet <= 1'b1;
      end
      wait_drained();
      configure(LIMIT_PLAN[p], TMO_PLAN[p]);
      if (p == 2) next_seq = 32'hFFFF_FFF0;
      else if (p == 4) next_seq = $urandom;
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        random_command(counted);
        if (counted) counted_items++;
      end
    end

    wait_drained();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
src/gbn_pkg.sv
src/gbn_if.sv
src/gbn_cfg.sv
src/go_back_n_sender_window.sv
tb/gbn_window_checker.sv
tb/go_back_n_sender_window_test.sv
